/* src/assert_macros.svh */
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property, also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* src/ewzs_pkg.sv */
// Package for the EWMA z-score spike detector: widths, register codes,
// state enums and command structs. Depends on nothing.
`default_nettype none
package ewzs_pkg;

   localparam int SAMPLE_BITS   = 48;
   localparam int TAG_BITS      = 4;
   localparam int POSITION_BITS = 32;
   localparam int ALPHA_BITS    = 17;
   localparam int ZLIM_BITS     = 16;
   localparam int WARM_BITS     = 16;
   localparam int FLOOR_BITS    = 63;
   localparam int VAR_BITS      = 64;
   localparam int Z_BITS        = 32;

   localparam int MUL_BITS      = 64;
   localparam int DIGIT_BITS    = 16;
   localparam int MUL_DIGITS    = MUL_BITS / DIGIT_BITS;
   localparam int MUL_CNT_BITS  = $clog2(MUL_DIGITS + 1);
   localparam int PROD_BITS     = 2 * MUL_BITS;

   localparam int ROOT_BITS     = 32;
   localparam int DIV_STEPS     = 31;
   localparam int SQRT_STEPS    = 32;
   localparam int SD_CNT_BITS   = 6;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 63;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SMOOTHING = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Z_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARMUP    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VAR_FLOOR = 2'd3;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE      = 17'd65536;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET    = 17'd6554;
   localparam logic [ZLIM_BITS-1:0]  ZLIM_RESET     = 16'd768;
   localparam logic [WARM_BITS-1:0]  WARM_RESET     = 16'd8;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET    = 63'd1;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_STEP, S_AD2, S_VARN, S_TEST, S_SQRT, S_ZCHK, S_DIV, S_EMIT
   } state_type;

   typedef enum logic {
      SD_SQRT, SD_DIV
   } sd_mode_type;

   typedef struct packed {
      logic                start;
      logic [MUL_BITS-1:0] a;
      logic [MUL_BITS-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                start;
      sd_mode_type         mode;
      logic [VAR_BITS-1:0] operand;   // radicand, or dividend magnitude
      logic [ROOT_BITS-1:0] divisor;
   } sd_cmd_type;

endpackage
`default_nettype wire

/* src/ewzs_if.sv */
// Request and response channel interfaces of the spike detector.
// Depends on ewzs_pkg.
`default_nettype none
interface ewzs_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ewzs_pkg::SAMPLE_BITS-1:0] sample;
   logic                                   series_start;
   logic [ewzs_pkg::TAG_BITS-1:0]          metric_tag;
   modport source (output valid, sample, series_start, metric_tag, input ready);
   modport sink   (input valid, sample, series_start, metric_tag, output ready);
endinterface

interface ewzs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [ewzs_pkg::TAG_BITS-1:0]          event_metric;
   logic [ewzs_pkg::POSITION_BITS-1:0]     event_position;
   logic signed [ewzs_pkg::SAMPLE_BITS-1:0] event_value;
   logic signed [ewzs_pkg::Z_BITS-1:0]     z_score;
   modport source (output valid, event_metric, event_position, event_value, z_score,
                   input ready);
   modport sink   (input valid, event_metric, event_position, event_value, z_score,
                   output ready);
endinterface
`default_nettype wire

/* src/ewzs_mul.sv */
// Digit-serial multiplier: 64 x 64 bits as four 64 x 16 steps, MSB digit first.
// Depends on ewzs_pkg.
`default_nettype none
module ewzs_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  ewzs_pkg::mul_cmd_type             mul_cmd,
   output logic                              mul_done,
   output logic [ewzs_pkg::PROD_BITS-1:0]    mul_product
);
   localparam int MB = ewzs_pkg::MUL_BITS;
   localparam int DB = ewzs_pkg::DIGIT_BITS;
   localparam int PB = ewzs_pkg::PROD_BITS;

   logic [MB-1:0] a_ff, b_ff;
   logic [PB-1:0] acc_ff, acc_in;
   logic [MB+DB-1:0] partial;
   logic [ewzs_pkg::MUL_CNT_BITS-1:0] cnt_ff;
   logic done_ff;

   always_comb begin
      partial = a_ff * b_ff[MB-1 -: DB];
      acc_in  = {acc_ff[PB-DB-1:0], {DB{1'b0}}} + {{(PB-MB-DB){1'b0}}, partial};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_cmd.start) begin
            cnt_ff <= ewzs_pkg::MUL_CNT_BITS'(ewzs_pkg::MUL_DIGITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == ewzs_pkg::MUL_CNT_BITS'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_cmd.start) begin
         a_ff   <= mul_cmd.a;
         b_ff   <= mul_cmd.b;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[MB-DB-1:0], {DB{1'b0}}};
      end
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;
endmodule
`default_nettype wire

/* src/ewzs_sqdiv.sv */
// Shared shift-subtract unit: 64-bit integer square root (2 bits a step)
// and 31-bit quotient restoring divide, one step per cycle. Depends on ewzs_pkg.
`default_nettype none
module ewzs_sqdiv (
   input  logic                              clock,
   input  logic                              reset,
   input  ewzs_pkg::sd_cmd_type              sd_cmd,
   output logic                              sd_done,
   output logic [ewzs_pkg::ROOT_BITS-1:0]    sd_result
);
   localparam int VB = ewzs_pkg::VAR_BITS;
   localparam int RB = ewzs_pkg::ROOT_BITS;
   localparam int NB = ewzs_pkg::DIV_STEPS;

   ewzs_pkg::sd_mode_type mode_ff;
   logic [VB-1:0] rem_ff, root_ff, bit_ff;
   logic [NB-1:0] num_ff;
   logic [RB-1:0] dvs_ff;
   logic [ewzs_pkg::SD_CNT_BITS-1:0] cnt_ff;
   logic done_ff;
   logic [VB-1:0] lhs, rhs;
   logic [VB:0]   diff;
   logic          ge;

   always_comb begin
      if (mode_ff == ewzs_pkg::SD_SQRT) begin
         lhs = rem_ff;
         rhs = root_ff | bit_ff;   // root never overlaps the current bit
      end else begin
         lhs = {rem_ff[VB-2:0], num_ff[NB-1]};
         rhs = {{(VB-RB){1'b0}}, dvs_ff};
      end
      diff = {1'b0, lhs} - {1'b0, rhs};
      ge   = ~diff[VB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (sd_cmd.start) begin
            cnt_ff <= (sd_cmd.mode == ewzs_pkg::SD_SQRT)
                      ? ewzs_pkg::SD_CNT_BITS'(ewzs_pkg::SQRT_STEPS)
                      : ewzs_pkg::SD_CNT_BITS'(ewzs_pkg::DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == ewzs_pkg::SD_CNT_BITS'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sd_cmd.start) begin
         mode_ff <= sd_cmd.mode;
         dvs_ff  <= sd_cmd.divisor;
         root_ff <= '0;
         bit_ff  <= {2'b01, {(VB-2){1'b0}}};
         if (sd_cmd.mode == ewzs_pkg::SD_SQRT) begin
            rem_ff <= sd_cmd.operand;
            num_ff <= '0;
         end else begin
            // dividend is operand << 16; first partial remainder is dividend >> 31
            rem_ff <= sd_cmd.operand >> (NB - 16);
            num_ff <= {sd_cmd.operand[NB-17:0], 16'b0};
         end
      end else if (cnt_ff != '0) begin
         if (mode_ff == ewzs_pkg::SD_SQRT) begin
            if (ge) begin
               rem_ff  <= diff[VB-1:0];
               root_ff <= (root_ff >> 1) | bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end else begin
            rem_ff  <= ge ? diff[VB-1:0] : lhs;
            root_ff <= {root_ff[VB-2:0], ge};
            num_ff  <= {num_ff[NB-2:0], 1'b0};
         end
      end
   end

   assign sd_done   = done_ff;
   assign sd_result = root_ff[RB-1:0];
endmodule
`default_nettype wire

/* src/ewma_zscore_spike_detector.sv */
// EWMA z-score spike detector, top level: sequencer, series state, config.
// Depends on ewzs_pkg, ewzs_if, ewzs_mul, ewzs_sqdiv.
//
// Usage:
//  - req_if carries one sample per request (sample, series_start, metric_tag).
//    req_if.ready is high only while the sequencer is idle; one request is
//    worked on at a time.
//  - rsp_if carries zero or one event per request: tag, position, sample, z.
//  - csr_* writes one of four registers per cycle; write only while idle.
// Sequence:
//  - A series start (or any request with no open series) seeds the series and
//    never emits. Other requests run three 4-step digit-serial multiplies (mean
//    step, a*d^2, variance scale); when the z test is not skipped, a 32-step
//    square root and, unless the quotient saturates, a 31-step divide follow in
//    the shared shift-subtract unit.
// Reset: synchronous, clears the series state, no series open, registers
//    return to alpha 6554, z limit 768 (Q8.8), warm-up 8, floor 1.
// Stall: the event sits in an output register; a new request is taken while
//    it waits. A second event waits in its last step until the first is taken.
`default_nettype none
module ewma_zscore_spike_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   ewzs_req_if.sink                              req_if,
   ewzs_rsp_if.source                            rsp_if,
   input  logic                                  csr_write_en,
   input  logic [ewzs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ewzs_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   localparam int SB = ewzs_pkg::SAMPLE_BITS;
   localparam int PB = ewzs_pkg::POSITION_BITS;
   localparam int VB = ewzs_pkg::VAR_BITS;
   localparam int MB = ewzs_pkg::MUL_BITS;
   localparam int RB = ewzs_pkg::ROOT_BITS;
   localparam int ZB = ewzs_pkg::Z_BITS;
   localparam int AB = ewzs_pkg::ALPHA_BITS;

   ewzs_pkg::state_type state_ff, state_in;

   // configuration
   logic [AB-1:0]                   alpha_cfg_ff;
   logic [ewzs_pkg::ZLIM_BITS-1:0]  zlim_ff;
   logic [ewzs_pkg::WARM_BITS-1:0]  warm_ff;
   logic [ewzs_pkg::FLOOR_BITS-1:0] floor_ff;

   // series state
   logic signed [SB-1:0] mean_ff, mean_in;
   logic [VB-1:0]        var_ff, var_in;
   logic [PB-1:0]        pos_ff, pos_in;
   logic                 open_ff, open_in;

   // request capture and working values
   logic signed [SB-1:0]          sample_ff;
   logic                          start_ff;
   logic [ewzs_pkg::TAG_BITS-1:0] tag_ff;
   logic [SB-1:0]                 mag_ff, mag_in, step_ff, step_in;
   logic                          neg_ff, neg_in;
   logic [VB-1:0]                 varn_ff, varn_in;
   logic [RB-1:0]                 sigma_ff, sigma_in;
   logic [ZB-1:0]                 zmag_ff, zmag_in;
   logic                          capture;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;

   // datapath helpers
   logic [AB-1:0]   alpha;
   logic signed [SB:0] diff;
   logic [VB-1:0]   ad2, sum;
   logic [VB:0]     sum_wide;

   ewzs_pkg::mul_cmd_type mul_cmd;
   logic                  mul_done;
   logic [ewzs_pkg::PROD_BITS-1:0] mul_product;
   ewzs_pkg::sd_cmd_type  sd_cmd;
   logic                  sd_done;
   logic [RB-1:0]         sd_result;

   ewzs_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_cmd     (mul_cmd),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   ewzs_sqdiv u_sqdiv (
      .clock     (clock),
      .reset     (reset),
      .sd_cmd    (sd_cmd),
      .sd_done   (sd_done),
      .sd_result (sd_result)
   );

   assign capture = req_if.valid & req_if.ready;
   assign req_if.ready = (state_ff == ewzs_pkg::S_IDLE);

   // alpha above one acts as one
   assign alpha = (alpha_cfg_ff > ewzs_pkg::ALPHA_ONE) ? ewzs_pkg::ALPHA_ONE : alpha_cfg_ff;

   always_comb begin
      diff = {sample_ff[SB-1], sample_ff} - {mean_ff[SB-1], mean_ff};
      // |d| is at most 2^48 - 1, so the magnitude fits the sample width
      neg_in = diff[SB];
      mag_in = neg_in ? SB'(-diff) : diff[SB-1:0];
      // a*d^2 saturates to 64 bits, then the sum saturates
      ad2      = (|mul_product[2*MB-1:MB]) ? {VB{1'b1}} : mul_product[VB-1:0];
      sum_wide = {1'b0, var_ff} + {1'b0, ad2};
      sum      = sum_wide[VB] ? {VB{1'b1}} : sum_wide[VB-1:0];
      step_in  = mul_product[16 +: SB];
      varn_in  = (|mul_product[2*MB-1:VB+16]) ? {VB{1'b1}} : mul_product[16 +: VB];
   end

   always_comb begin
      state_in = state_ff;
      mean_in  = mean_ff;
      var_in   = var_ff;
      pos_in   = pos_ff;
      open_in  = open_ff;
      sigma_in = sigma_ff;
      zmag_in  = zmag_ff;
      rsp_load = 1'b0;
      mul_cmd  = '{start: 1'b0, a: '0, b: '0};
      sd_cmd   = '{start: 1'b0, mode: ewzs_pkg::SD_SQRT, operand: '0, divisor: '0};
      unique case (state_ff)
         ewzs_pkg::S_IDLE: begin
            if (capture) begin
               state_in = ewzs_pkg::S_LOAD;
            end
         end
         ewzs_pkg::S_LOAD: begin
            if (start_ff || !open_ff) begin
               // seed a new series; never emits
               mean_in  = sample_ff;
               var_in   = '0;
               pos_in   = '0;
               open_in  = 1'b1;
               state_in = ewzs_pkg::S_IDLE;
            end else begin
               if (pos_ff != {PB{1'b1}}) begin
                  pos_in = pos_ff + 1'b1;
               end
               mul_cmd  = '{start: 1'b1, a: MB'(mag_in), b: MB'(alpha)};
               state_in = ewzs_pkg::S_STEP;
            end
         end
         ewzs_pkg::S_STEP: begin
            if (mul_done) begin
               mul_cmd  = '{start: 1'b1, a: MB'(step_in), b: MB'(mag_ff)};
               state_in = ewzs_pkg::S_AD2;
            end
         end
         ewzs_pkg::S_AD2: begin
            if (mul_done) begin
               mul_cmd  = '{start: 1'b1, a: sum, b: MB'(ewzs_pkg::ALPHA_ONE - alpha)};
               state_in = ewzs_pkg::S_VARN;
            end
         end
         ewzs_pkg::S_VARN: begin
            if (mul_done) begin
               state_in = ewzs_pkg::S_TEST;
            end
         end
         ewzs_pkg::S_TEST: begin
            // mean and variance commit here; the z path needs only mag and varn
            mean_in = neg_ff ? (mean_ff - $signed(step_ff)) : (mean_ff + $signed(step_ff));
            var_in  = varn_ff;
            if ((pos_ff >= PB'(warm_ff)) && (varn_ff > VB'(floor_ff))) begin
               sd_cmd   = '{start: 1'b1, mode: ewzs_pkg::SD_SQRT, operand: varn_ff,
                            divisor: '0};
               state_in = ewzs_pkg::S_SQRT;
            end else begin
               state_in = ewzs_pkg::S_IDLE;
            end
         end
         ewzs_pkg::S_SQRT: begin
            if (sd_done) begin
               sigma_in = sd_result;
               state_in = ewzs_pkg::S_ZCHK;
            end
         end
         ewzs_pkg::S_ZCHK: begin
            if ({1'b0, mag_ff} >= {sigma_ff, 15'b0}) begin
               // quotient would not fit: saturate
               zmag_in  = neg_ff ? {1'b1, {(ZB-1){1'b0}}} : {1'b0, {(ZB-1){1'b1}}};
               state_in = ewzs_pkg::S_EMIT;
            end else begin
               sd_cmd   = '{start: 1'b1, mode: ewzs_pkg::SD_DIV, operand: VB'(mag_ff),
                            divisor: sigma_ff};
               state_in = ewzs_pkg::S_DIV;
            end
         end
         ewzs_pkg::S_DIV: begin
            if (sd_done) begin
               zmag_in  = sd_result;
               state_in = (sd_result > RB'({zlim_ff, 8'b0})) ? ewzs_pkg::S_EMIT
                                                               : ewzs_pkg::S_IDLE;
            end
         end
         ewzs_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ewzs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ewzs_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ewzs_pkg::S_IDLE;
         mean_ff      <= '0;
         var_ff       <= '0;
         pos_ff       <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         pos_ff       <= pos_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_cfg_ff <= ewzs_pkg::ALPHA_RESET;
         zlim_ff      <= ewzs_pkg::ZLIM_RESET;
         warm_ff      <= ewzs_pkg::WARM_RESET;
         floor_ff     <= ewzs_pkg::FLOOR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ewzs_pkg::CSR_SMOOTHING: alpha_cfg_ff <= csr_write_data[AB-1:0];
            ewzs_pkg::CSR_Z_LIMIT:   zlim_ff <= csr_write_data[ewzs_pkg::ZLIM_BITS-1:0];
            ewzs_pkg::CSR_WARMUP:    warm_ff <= csr_write_data[ewzs_pkg::WARM_BITS-1:0];
            ewzs_pkg::CSR_VAR_FLOOR: floor_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (capture) begin
         sample_ff <= req_if.sample;
         start_ff  <= req_if.series_start;
         tag_ff    <= req_if.metric_tag;
      end
      if (state_ff == ewzs_pkg::S_LOAD) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (state_ff == ewzs_pkg::S_STEP && mul_done) begin
         step_ff <= step_in;
      end
      if (state_ff == ewzs_pkg::S_VARN && mul_done) begin
         varn_ff <= varn_in;
      end
      sigma_ff <= sigma_in;
      zmag_ff  <= zmag_in;
      if (rsp_load) begin
         rsp_if.event_metric   <= tag_ff;
         rsp_if.event_position <= pos_ff;
         rsp_if.event_value    <= sample_ff;
         rsp_if.z_score        <= neg_ff ? $signed(-zmag_ff) : $signed(zmag_ff);
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
endmodule
`default_nettype wire

/* src/ewzs_checker.sv */
// Port-level checker for the spike detector, bound to the top level.
// Depends on assert_macros.svh and ewzs_pkg.
`default_nettype none
`include "assert_macros.svh"
module ewzs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ewzs_pkg::Z_BITS-1:0] rsp_z_score
);
   `ASSERT_CLK_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_busy_after_request, clock, reset, req_valid && req_ready |=> !req_ready)
   `ASSERT_CLK(a_event_z_nonzero, clock, reset, rsp_valid |-> rsp_z_score != 0)
   `ASSERT_CLK(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_z_holds, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_z_score))
endmodule

bind ewma_zscore_spike_detector ewzs_checker u_ewzs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_z_score (rsp_if.z_score)
);
`default_nettype wire

/* verif/ewma_zscore_spike_detector_checker.sv */
// Checker for the EWMA z-score spike detector: predicts events from accepted requests
// and compares them with the events taken from the response channel.
// Depends on ewzs_pkg and ewzs_if.
`timescale 1ns / 100ps
`default_nettype none
module ewma_zscore_spike_detector_checker (
   input  logic                                clock,
   input  logic                                reset,
   ewzs_req_if                                 req_mon,
   ewzs_rsp_if                                 rsp_mon,
   input  logic                                csr_write_en,
   input  logic [ewzs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ewzs_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output int                                  fail_count,
   output int                                  events_pending
);
   import ewzs_pkg::*;

   typedef struct packed {
      logic [TAG_BITS-1:0]      metric;
      logic [POSITION_BITS-1:0] position;
      logic [SAMPLE_BITS-1:0]   value;
      logic [Z_BITS-1:0]        z;
   } spike_t;

   spike_t spike_q[$];

   logic [ALPHA_BITS-1:0]    alpha_reg;
   logic [ZLIM_BITS-1:0]     zlim_reg;
   logic [WARM_BITS-1:0]     warm_reg;
   logic [FLOOR_BITS-1:0]    floor_reg;
   logic [63:0]              mean_st;
   logic [63:0]              var_st;
   logic [POSITION_BITS-1:0] pos_st;
   logic                     open_st;

   assign events_pending = spike_q.size();

   // (a * b) >> 16, saturated to 64 bits
   function automatic logic [63:0] mul_q16_sat(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return (|p[127:80]) ? '1 : p[79:16];
   endfunction

   task automatic predict_spike(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                                input logic [TAG_BITS-1:0] tag,
                                output logic hit, output spike_t ev);
      logic [63:0]  raw, d, mag, step, ad2, var_next, sigma, t, zmag;
      logic [64:0]  sum;
      logic [127:0] p;
      logic [16:0]  a;
      logic         neg;
      hit = 1'b0;
      ev  = '0;
      raw = {{(64-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
      if (start || !open_st) begin
         mean_st = raw;
         var_st  = '0;
         pos_st  = '0;
         open_st = 1'b1;
         return;
      end
      d    = raw - mean_st;
      neg  = d[63];
      mag  = neg ? -d : d;
      a    = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
      step = mul_q16_sat(mag, {47'b0, a});
      p    = {64'b0, step} * {64'b0, mag};
      ad2  = (|p[127:64]) ? '1 : p[63:0];
      sum  = {1'b0, var_st} + {1'b0, ad2};
      var_next = mul_q16_sat(sum[64] ? '1 : sum[63:0], 64'd65536 - {47'b0, a});
      if (pos_st != '1) pos_st = pos_st + 1;
      if (pos_st >= warm_reg && var_next > {1'b0, floor_reg}) begin
         // integer square root, 32-bit result
         sigma = '0;
         for (int b = 31; b >= 0; b--) begin
            t = sigma | (64'd1 << b);
            if (t * t <= var_next) sigma = t;
         end
         if (mag >= (sigma << 15)) begin
            zmag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            hit  = 1'b1;
         end else begin
            zmag = (mag << 16) / sigma;
            hit  = zmag > ({48'b0, zlim_reg} << 8);
         end
         if (hit) begin
            ev.metric   = tag;
            ev.position = pos_st;
            ev.value    = smp;
            ev.z        = neg ? (32'd0 - zmag[31:0]) : zmag[31:0];
         end
      end
      mean_st = neg ? mean_st - step : mean_st + step;
      var_st  = var_next;
   endtask

   always @(posedge clock) begin
      logic   hit;
      spike_t ev, got;
      if (reset) begin
         alpha_reg  <= ALPHA_RESET;
         zlim_reg   <= ZLIM_RESET;
         warm_reg   <= WARM_RESET;
         floor_reg  <= FLOOR_RESET;
         mean_st    = '0;
         var_st     = '0;
         pos_st     = '0;
         open_st    = 1'b0;
         fail_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SMOOTHING: alpha_reg <= csr_write_data[ALPHA_BITS-1:0];
               CSR_Z_LIMIT:   zlim_reg  <= csr_write_data[ZLIM_BITS-1:0];
               CSR_WARMUP:    warm_reg  <= csr_write_data[WARM_BITS-1:0];
               CSR_VAR_FLOOR: floor_reg <= csr_write_data[FLOOR_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_spike(req_mon.sample, req_mon.series_start, req_mon.metric_tag, hit, ev);
            if (hit) spike_q.push_back(ev);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.event_metric, rsp_mon.event_position, rsp_mon.event_value,
                   rsp_mon.z_score};
            if (spike_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected event: %p", got);
            end else begin
               ev = spike_q.pop_front();
               if (got.metric != ev.metric || got.position != ev.position ||
                   got.value != ev.value || got.z != ev.z) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("event mismatch: expected %p, got %p", ev, got);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* verif/ewma_zscore_spike_detector_tb.sv */
// Testbench top for the EWMA z-score spike detector: clock, reset, register
// phases, request stimulus and response back-pressure. Depends on ewzs_pkg,
// ewzs_if, the detector RTL and ewma_zscore_spike_detector_checker.
`timescale 1ns / 100ps
`default_nettype none
module ewma_zscore_spike_detector_tb;
   import ewzs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SMOOTHING;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   int fail_count, events_pending;
   int send_idle_pct = 0;   // chance of a gap after each request
   int recv_idle_pct = 0;   // chance of ready low in a cycle
   int hold_off      = 0;   // long receiver stall, counted down by the receiver
   int sent          = 0;

   ewzs_req_if req_ch();
   ewzs_rsp_if rsp_ch();

   ewma_zscore_spike_detector DUT (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   ewma_zscore_spike_detector_checker CHK (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .events_pending(events_pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.series_start = 1'b0;
      req_ch.metric_tag = '0;
      rsp_ch.ready = 1'b0;
   end

   // Receiver: random ready, with an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #20ms;
      $display("ewma_zscore_spike_detector test failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   // One request; waits for the handshake, then maybe leaves a gap
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic start,
                              input logic [TAG_BITS-1:0] tag);
      req_ch.valid        <= 1'b1;
      req_ch.sample       <= smp;
      req_ch.series_start <= start;
      req_ch.metric_tag   <= tag;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Block must be idle before registers change: events drained, then the
   // worst-case latency of a request that makes no event.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // A series: start, steady noise around a base, rare spikes, stray random requests
   task automatic run_series(input int len);
      logic signed [SAMPLE_BITS-1:0] base, smp;
      logic [TAG_BITS-1:0] tag;
      int nb;
      base = SAMPLE_BITS'($signed({$urandom, $urandom}) >>> $urandom_range(0, 40));
      nb   = $urandom_range(4, 30);
      tag  = TAG_BITS'($urandom_range(0, 15));
      send_sample(base, 1'b1, tag);
      for (int i = 1; i < len; i++) begin
         smp = base + SAMPLE_BITS'($signed({1'b0, 31'($urandom)} >> (31 - nb)))
               - (48'sd1 <<< (nb - 1));
         if ($urandom_range(99) < 6)
            smp = base + (($urandom_range(1) ? 48'sd1 : -48'sd1) <<< (nb + $urandom_range(1, 8)));
         if ($urandom_range(99) < 3) tag = TAG_BITS'($urandom_range(0, 15));  // tag change
         if ($urandom_range(99) < 4)
            send_sample(SAMPLE_BITS'({$urandom, $urandom}), 1'($urandom_range(1)),
                        TAG_BITS'($urandom_range(0, 15)));
         else
            send_sample(smp, 1'b0, tag);
      end
   endtask

   task automatic random_phase(input int items);
      int target;
      target = sent + items;
      while (sent < target) run_series($urandom_range(6, 40));
   endtask

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: reset registers; sender idles 32%, receiver 66%
      send_idle_pct = 32;
      recv_idle_pct = 66;
      send_sample(48'sd100, 1'b0, 4'd3);       // non-start with nothing open acts as start
      for (int i = 0; i < 10; i++) send_sample(48'sd100 + i, 1'b0, 4'd3);
      send_sample(SMP_MAX, 1'b0, 4'hF);        // huge jump after warm-up
      send_sample(SMP_MIN, 1'b0, 4'h0);
      send_sample(SMP_MAX, 1'b0, 4'hA);
      send_sample(48'sd0, 1'b1, 4'd5);         // start never emits
      send_sample(SMP_MIN, 1'b1, 4'd6);
      send_sample(SMP_MAX, 1'b0, 4'd6);
      random_phase(430);
      drain();

      // Phase 2: alpha above one, zero limit, no warm-up, zero floor
      write_reg(CSR_SMOOTHING, 63'd131071);
      write_reg(CSR_Z_LIMIT, 63'd0);
      write_reg(CSR_WARMUP, 63'd0);
      write_reg(CSR_VAR_FLOOR, 63'd0);
      send_idle_pct = 66;
      recv_idle_pct = 32;
      send_sample(SMP_MAX, 1'b1, 4'd1);
      send_sample(SMP_MIN, 1'b0, 4'd1);
      send_sample(SMP_MAX, 1'b0, 4'd2);
      random_phase(200);
      drain();
      write_reg(CSR_SMOOTHING, 63'd65536);
      write_reg(CSR_SMOOTHING, 63'd0);         // mean never moves, variance never grows
      random_phase(60);
      drain();

      // Phase 3: maximum limit, warm-up and floor, then a moderate setting
      write_reg(CSR_SMOOTHING, 63'd1);
      write_reg(CSR_Z_LIMIT, 63'd65535);
      write_reg(CSR_WARMUP, 63'd65535);
      write_reg(CSR_VAR_FLOOR, {CSR_DATA_BITS{1'b1}});
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(80);
      drain();
      write_reg(CSR_SMOOTHING, 63'd20000);
      write_reg(CSR_Z_LIMIT, 63'd384);
      write_reg(CSR_WARMUP, 63'd3);
      write_reg(CSR_VAR_FLOOR, 63'd1000);
      hold_off = 3000;                          // receiver stalls while requests keep coming
      random_phase(630);

      drain();
      if (fail_count == 0 && events_pending == 0)
         $display("ewma_zscore_spike_detector test passed");
      else
         $display("ewma_zscore_spike_detector test failed");
      $finish;
   end
endmodule
`default_nettype wire
